FILE: rtl/core/mi3_pkg.sv
package mi3_pkg;

    // Fixed-point format of elements and results
    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;

    // Exact widths of the intermediate values
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int COF_W   = PROD_W + 1;
    localparam int CMAG_W  = PROD_W;
    localparam int DET_W   = 3 * ELEM_W + 1;
    localparam int DMAG_W  = DET_W - 1;
    localparam int NUM_SH  = 2 * FRAC_BITS + 1;
    localparam int NUM_RAW = (CMAG_W + NUM_SH > DMAG_W) ? CMAG_W + NUM_SH : DMAG_W;
    localparam int NUM_W   = NUM_RAW + 1;
    localparam int DEN_W   = DMAG_W + 1;
    localparam int QUO_W   = ELEM_W + 1;
    localparam int REM_W   = (NUM_W > DEN_W + QUO_W + 1) ? NUM_W : DEN_W + QUO_W + 1;

    localparam int NUM_EL  = 9;
    localparam int DIV_ST  = QUO_W + 2;

    // Element indexes of the cofactor products: cof = el[0]*el[1] - el[2]*el[3]
    localparam int PIDX [NUM_EL][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        elem_t m00;
        elem_t m01;
        elem_t m02;
        elem_t m10;
        elem_t m11;
        elem_t m12;
        elem_t m20;
        elem_t m21;
        elem_t m22;
    } mat_t;

    typedef struct packed {
        elem_t inv00;
        elem_t inv01;
        elem_t inv02;
        elem_t inv10;
        elem_t inv11;
        elem_t inv12;
        elem_t inv20;
        elem_t inv21;
        elem_t inv22;
        logic  singular;
    } inv_t;

    typedef struct packed {
        logic [NUM_EL-1:0][CMAG_W-1:0] cmag;
        logic [DMAG_W-1:0]             dmag;
        logic [NUM_EL-1:0]             neg;
        logic                          dz;
    } div_req_t;

endpackage

FILE: rtl/core/mi3_if.sv
interface mi3_mat_if;
    import mi3_pkg::*;

    logic valid;
    logic ready;
    mat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mi3_inv_if;
    import mi3_pkg::*;

    logic valid;
    logic ready;
    inv_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/matrix_inverse_3x3.sv
// Pipeline: 6 cofactor and determinant stages, 35 divider stages and
// 1 output register; the 33-step restoring divider sets the depth.
// Throughput: one matrix per cycle while the result side does not stall.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
module matrix_inverse_3x3 (
    input  logic      clk,
    input  logic      rst_n,
    mi3_mat_if.sink   matrix,
    mi3_inv_if.source result
);
    import mi3_pkg::*;

    localparam int FRONT_ST = 6;

    logic [FRONT_ST-1:0] fv_reg;
    logic [FRONT_ST:0]   fen;
    logic                div_ready;

    elem_t el [NUM_EL];
    assign el[0] = matrix.data.m00;
    assign el[1] = matrix.data.m01;
    assign el[2] = matrix.data.m02;
    assign el[3] = matrix.data.m10;
    assign el[4] = matrix.data.m11;
    assign el[5] = matrix.data.m12;
    assign el[6] = matrix.data.m20;
    assign el[7] = matrix.data.m21;
    assign el[8] = matrix.data.m22;

    // Advance a stage when it is empty or its successor advances
    assign fen[FRONT_ST] = div_ready;
    genvar j, k;
    generate
        for (j = 0; j < FRONT_ST; j++) begin : g_en
            assign fen[j] = !fv_reg[j] || fen[j+1];
        end
    endgenerate
    assign matrix.ready = fen[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < FRONT_ST; s++)
            begin
                if (fen[s])
                begin
                    fv_reg[s] <= (s == 0) ? matrix.valid : fv_reg[s-1];
                end
            end
        end
    end

    // Stage 1: the eighteen cofactor products
    logic signed [PROD_W-1:0] prod_reg [NUM_EL][2];
    elem_t                    row1_reg [3];
    generate
        for (k = 0; k < NUM_EL; k++) begin : g_prod
            always_ff @(posedge clk)
            begin
                if (fen[0])
                begin
                    prod_reg[k][0] <= PROD_W'(el[PIDX[k][0]]) * PROD_W'(el[PIDX[k][1]]);
                    prod_reg[k][1] <= PROD_W'(el[PIDX[k][2]]) * PROD_W'(el[PIDX[k][3]]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (fen[0])
        begin
            row1_reg[0] <= el[0];
            row1_reg[1] <= el[1];
            row1_reg[2] <= el[2];
        end
    end

    // Stage 2: cofactors
    logic signed [COF_W-1:0] cof2_reg [NUM_EL];
    elem_t                   row2_reg [3];
    always_ff @(posedge clk)
    begin
        if (fen[1])
        begin
            for (int n = 0; n < NUM_EL; n++)
            begin
                cof2_reg[n] <= COF_W'(prod_reg[n][0]) - COF_W'(prod_reg[n][1]);
            end
            row2_reg <= row1_reg;
        end
    end

    // Stage 3: first-row expansion, cofactor split at bit 32 into two partial products
    logic signed [COF_W-1:0] plo_reg  [3];
    logic signed [COF_W-1:0] phi_reg  [3];
    logic signed [COF_W-1:0] cof3_reg [NUM_EL];
    always_ff @(posedge clk)
    begin
        if (fen[2])
        begin
            for (int t = 0; t < 3; t++)
            begin
                plo_reg[t] <= COF_W'(row2_reg[t])
                            * COF_W'($signed({1'b0, cof2_reg[3*t][ELEM_W-1:0]}));
                phi_reg[t] <= COF_W'(row2_reg[t])
                            * COF_W'($signed(cof2_reg[3*t][COF_W-1:ELEM_W]));
            end
            cof3_reg <= cof2_reg;
        end
    end

    // Stage 4: combine partial products
    logic signed [DET_W-1:0] term_reg [3];
    logic signed [COF_W-1:0] cof4_reg [NUM_EL];
    always_ff @(posedge clk)
    begin
        if (fen[3])
        begin
            for (int t = 0; t < 3; t++)
            begin
                term_reg[t] <= (DET_W'(phi_reg[t]) <<< ELEM_W) + DET_W'(plo_reg[t]);
            end
            cof4_reg <= cof3_reg;
        end
    end

    // Stage 5: determinant
    logic signed [DET_W-1:0] det_reg;
    logic signed [COF_W-1:0] cof5_reg [NUM_EL];
    always_ff @(posedge clk)
    begin
        if (fen[4])
        begin
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            cof5_reg <= cof4_reg;
        end
    end

    // Stage 6: magnitudes and signs for the divider
    div_req_t req_reg;
    div_req_t req_next;
    always_comb
    begin
        logic [DET_W-1:0] dabs;
        logic [COF_W-1:0] cabs;
        dabs = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        req_next.dmag = dabs[DMAG_W-1:0];
        req_next.dz   = (det_reg == '0);
        for (int n = 0; n < NUM_EL; n++)
        begin
            cabs = cof5_reg[n][COF_W-1] ? COF_W'(-cof5_reg[n]) : COF_W'(cof5_reg[n]);
            req_next.cmag[n] = cabs[CMAG_W-1:0];
            req_next.neg[n]  = cof5_reg[n][COF_W-1] ^ det_reg[DET_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen[5])
        begin
            req_reg <= req_next;
        end
    end

    mi3_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (fv_reg[FRONT_ST-1]),
        .req_ready (div_ready),
        .req       (req_reg),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.data)
    );

endmodule

FILE: rtl/core/mi3_div.sv
module mi3_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  mi3_pkg::div_req_t req,
    output logic             out_valid,
    input  logic             out_ready,
    output mi3_pkg::inv_t    out_data
);
    import mi3_pkg::*;

    localparam logic [QUO_W-1:0] LIM_POS = {2'b00, {(ELEM_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] LIM_NEG = {2'b01, {(ELEM_W-1){1'b0}}};
    localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

    logic [DIV_ST-1:0] v_reg;
    logic [DIV_ST:0]   en;

    logic [REM_W-1:0]  rem_reg [DIV_ST][NUM_EL];
    logic [QUO_W-1:0]  quo_reg [DIV_ST][NUM_EL];
    logic [DEN_W-1:0]  den_reg [DIV_ST];
    logic [NUM_EL-1:0] neg_reg [DIV_ST];
    logic [NUM_EL-1:0] ovf_reg [DIV_ST];
    logic [DIV_ST-1:0] dz_reg;

    logic  out_valid_reg;
    inv_t  out_reg;
    inv_t  out_next;

    // Advance a stage when it is empty or its successor advances
    assign en[DIV_ST] = !out_valid_reg || out_ready;
    genvar j, k;
    generate
        for (j = 0; j < DIV_ST; j++) begin : g_en
            assign en[j] = !v_reg[j] || en[j+1];
        end
    endgenerate
    assign req_ready = en[0];

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < DIV_ST; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= (s == 0) ? req_valid : v_reg[s-1];
                end
            end
        end
    end

    generate
        for (j = 0; j < DIV_ST; j++) begin : g_st
            logic [REM_W-1:0]  rem_next [NUM_EL];
            logic [QUO_W-1:0]  quo_next [NUM_EL];
            logic [NUM_EL-1:0] ovf_next;

            for (k = 0; k < NUM_EL; k++) begin : g_ln
                if (j == 0) begin : g_load
                    // Form numerator 2|C|*2^(2F) + |D|
                    assign rem_next[k] = (REM_W'(req.cmag[k]) << NUM_SH) + REM_W'(req.dmag);
                    assign quo_next[k] = '0;
                    assign ovf_next[k] = 1'b0;
                end
                else if (j == 1) begin : g_ovf
                    // Flag a quotient of 2^QUO_W or more
                    assign rem_next[k] = rem_reg[0][k];
                    assign quo_next[k] = quo_reg[0][k];
                    assign ovf_next[k] = rem_reg[0][k] >= (REM_W'(den_reg[0]) << QUO_W);
                end
                else begin : g_step
                    localparam int SH = DIV_ST - 1 - j;
                    logic [REM_W-1:0] dsh;
                    logic             take;
                    // Restoring step: one quotient bit
                    assign dsh  = REM_W'(den_reg[j-1]) << SH;
                    assign take = rem_reg[j-1][k] >= dsh;
                    assign rem_next[k] = take ? rem_reg[j-1][k] - dsh : rem_reg[j-1][k];
                    assign quo_next[k] = quo_reg[j-1][k] | (QUO_W'(take) << SH);
                    assign ovf_next[k] = ovf_reg[j-1][k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    for (int n = 0; n < NUM_EL; n++)
                    begin
                        rem_reg[j][n] <= rem_next[n];
                        quo_reg[j][n] <= quo_next[n];
                    end
                    ovf_reg[j] <= ovf_next;
                    if (j == 0)
                    begin
                        den_reg[j] <= {req.dmag, 1'b0};
                        neg_reg[j] <= req.neg;
                        dz_reg[j]  <= req.dz;
                    end
                    else
                    begin
                        den_reg[j] <= den_reg[j-1];
                        neg_reg[j] <= neg_reg[j-1];
                        dz_reg[j]  <= dz_reg[j-1];
                    end
                end
            end
        end
    endgenerate

    // Apply sign, saturation and the zero-determinant case
    logic [ELEM_W-1:0] res [NUM_EL];
    logic [NUM_EL-1:0] sat;
    always_comb
    begin
        logic [QUO_W-1:0] q;
        logic             ng;
        for (int n = 0; n < NUM_EL; n++)
        begin
            q  = quo_reg[DIV_ST-1][n];
            ng = neg_reg[DIV_ST-1][n];
            sat[n] = ovf_reg[DIV_ST-1][n] || (ng ? (q > LIM_NEG) : (q > LIM_POS));
            if (dz_reg[DIV_ST-1])
            begin
                res[n] = '0;
            end
            else if (sat[n])
            begin
                res[n] = ng ? SAT_NEG : SAT_POS;
            end
            else
            begin
                res[n] = ng ? (~q[ELEM_W-1:0] + 1'b1) : q[ELEM_W-1:0];
            end
        end
        out_next.inv00    = res[0];
        out_next.inv01    = res[1];
        out_next.inv02    = res[2];
        out_next.inv10    = res[3];
        out_next.inv11    = res[4];
        out_next.inv12    = res[5];
        out_next.inv20    = res[6];
        out_next.inv21    = res[7];
        out_next.inv22    = res[8];
        out_next.singular = dz_reg[DIV_ST-1] || (|sat);
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en[DIV_ST])
        begin
            out_valid_reg <= v_reg[DIV_ST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_ST])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/mi3_checker.sv
module mi3_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input mi3_pkg::inv_t out_data
);
    import mi3_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // Block requests only when the pipeline is full behind a stalled result
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request refused with room in the pipeline");

    // Keep handshake signals known out of reset
    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_ready, out_valid, out_ready}))
        else $error("handshake signal unknown");

    // A presented result carries a fully known payload
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("result payload unknown");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (matrix.valid),
    .in_ready  (matrix.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

FILE: tb/matrix_inverse_3x3_tb.sv
module matrix_inverse_3x3_tb;
    import mi3_pkg::*;

    localparam int LATENCY   = 42;
    localparam int N_RANDOM  = 530;
    localparam int CYCLE_MAX = 200000;

    logic clk;
    logic rst_n;

    mi3_mat_if matrix_ch ();
    mi3_inv_if result_ch ();

    matrix_inverse_3x3 uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .matrix (matrix_ch.sink),
        .result (result_ch.source)
    );

    // Directed request with an optional typed-in answer
    typedef struct {
        mat_t m;
        logic known;
        inv_t ans;
    } vec_t;

    inv_t   pending_inverses[$];
    int     mismatches;
    int     cycles;
    int     stall_left;
    bit     calm;
    vec_t   vecs[$];

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Round cof * 2^(2F) / det to nearest, ties away, saturate
    function automatic elem_t scale_elem(logic signed [127:0] cof, logic signed [127:0] det,
                                         inout logic sat);
        logic        neg;
        logic [255:0] cm;
        logic [255:0] dm;
        logic [255:0] q;
        neg = (cof < 0) != (det < 0);
        cm  = (cof < 0) ? -cof : cof;
        dm  = (det < 0) ? -det : det;
        q   = ((cm << (2 * FRAC_BITS + 1)) + dm) / (dm << 1);
        if (q == 0)
            return '0;
        if (q > (neg ? 256'h8000_0000 : 256'h7FFF_FFFF))
        begin
            sat = 1'b1;
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic inv_t invert_matrix(mat_t m);
        logic signed [127:0] a, b, c, d, e, f, g, h, i, det;
        logic signed [127:0] cof[9];
        elem_t r[9];
        logic  sat;
        inv_t  o;
        a = m.m00; b = m.m01; c = m.m02;
        d = m.m10; e = m.m11; f = m.m12;
        g = m.m20; h = m.m21; i = m.m22;
        sat = 1'b0;
        det = a*e*i + b*f*g + c*d*h - g*e*c - h*f*a - i*d*b;
        if (det == 0)
        begin
            o = '0;
            o.singular = 1'b1;
            return o;
        end
        cof[0] = e*i - f*h; cof[1] = c*h - b*i; cof[2] = b*f - c*e;
        cof[3] = f*g - d*i; cof[4] = a*i - c*g; cof[5] = c*d - a*f;
        cof[6] = d*h - e*g; cof[7] = b*g - a*h; cof[8] = a*e - b*d;
        for (int k = 0; k < 9; k++)
            r[k] = scale_elem(cof[k], det, sat);
        o = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], sat};
        return o;
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
            2: return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
            3: return $signed(32'($urandom_range(0, 1))) <<< 16;
            default: return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
        endcase
    endfunction

    function automatic mat_t rand_matrix();
        mat_t m;
        int   kind;
        kind = $urandom_range(0, 9);
        m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
             rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        // Force some singular ones (repeated row, or a zero row) and some diagonal ones
        if (kind == 0)
            {m.m20, m.m21, m.m22} = {m.m00, m.m01, m.m02};
        else if (kind == 1)
            {m.m10, m.m11, m.m12} = '0;
        else if (kind == 2)
        begin
            m.m01 = 0; m.m02 = 0; m.m10 = 0; m.m12 = 0; m.m20 = 0; m.m21 = 0;
        end
        return m;
    endfunction

    function automatic void add_vec(mat_t m, logic known, inv_t ans);
        vec_t v;
        v.m = m; v.known = known; v.ans = ans;
        vecs.push_back(v);
    endfunction

    function automatic mat_t diag(elem_t x, elem_t y, elem_t z);
        mat_t m;
        m = '0;
        m.m00 = x; m.m11 = y; m.m22 = z;
        return m;
    endfunction

    // Accepted request: queue its inverse
    task automatic send_matrix(mat_t m, logic known, inv_t ans);
        matrix_ch.data  <= m;
        matrix_ch.valid <= 1'b1;
        do @(posedge clk); while (!matrix_ch.ready);
        pending_inverses.push_back(known ? ans : invert_matrix(m));
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            matrix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    // Random stall bursts on the result side
    always @(negedge clk)
    begin
        if (!rst_n || calm)
        begin
            result_ch.ready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                result_ch.ready <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 3);
            result_ch.ready <= 1'b0;
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        inv_t got;
        inv_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (pending_inverses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_inverses.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result differs: expected %h actual %h", want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_MAX)
        begin
            $display("matrix_inverse_3x3: mismatch");
            $finish;
        end
    end

    initial
    begin
        inv_t z;
        inv_t ident;
        mat_t m;
        mismatches = 0;
        cycles     = 0;
        stall_left = 0;
        calm       = 1'b0;
        rst_n      = 1'b0;
        matrix_ch.valid = 1'b0;
        matrix_ch.data  = '0;
        result_ch.ready = 1'b1;

        z = '0;
        z.singular = 1'b1;
        ident = '0;
        ident.inv00 = 32'sh1_0000; ident.inv11 = 32'sh1_0000; ident.inv22 = 32'sh1_0000;

        // Directed table
        add_vec('0, 1'b1, z);
        add_vec(diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000), 1'b1, ident);
        add_vec(diag(32'sh1_0000, 32'sh1_0000, 32'sh0), 1'b1, z);
        add_vec(diag(32'sh1, 32'sh1, 32'sh1), 1'b0, z);
        add_vec(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 1'b0, z);
        add_vec(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 1'b0, z);
        add_vec(diag(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1), 1'b0, z);
        add_vec(diag(32'sh2_0000, -32'sh2_0000, 32'sh3_0000), 1'b0, z);
        add_vec({9{32'sh7FFF_FFFF}}, 1'b1, z);
        add_vec({9{32'sh8000_0000}}, 1'b1, z);
        add_vec({9{32'shFFFF_FFFF}}, 1'b1, z);
        add_vec(diag(32'sh3_0000, 32'sh3_0000, 32'sh3_0000), 1'b0, z);
        add_vec(diag(32'sh0_8000, 32'sh1_0000, 32'sh1_0000), 1'b0, z);
        add_vec(diag(32'sh2_0000, 32'sh2_0000, 32'sh2_0000), 1'b0, z);
        m = {32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh0, 32'sh1_0000, 32'sh4_0000,
             32'sh5_0000, 32'sh6_0000, 32'sh0};
        add_vec(m, 1'b0, z);
        m = {32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0, 32'sh1234_5678, 32'shFEDC_BA98,
             32'sh7, 32'sh1, 32'shFFFF_0000, 32'sh3_0000};
        add_vec(m, 1'b0, z);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (vecs[k])
            send_matrix(vecs[k].m, vecs[k].known, vecs[k].ans);

        // Hold off until the pipeline drains once
        matrix_ch.valid <= 1'b0;
        while (pending_inverses.size() != 0)
            @(negedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - 100)
                calm = 1'b1;
            send_matrix(rand_matrix(), 1'b0, z);
        end
        matrix_ch.valid <= 1'b0;

        while (pending_inverses.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        if (mismatches == 0)
            $display("matrix_inverse_3x3: match");
        else
            $display("matrix_inverse_3x3: mismatch");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_if.sv
rtl/core/mi3_div.sv
rtl/core/matrix_inverse_3x3.sv
rtl/core/mi3_checker.sv
tb/matrix_inverse_3x3_tb.sv
